@@ design/lppu_pkg.sv @@
// lppu_pkg: shared types, bus map constants and timer constants for the lcd
// picture unit register block; no dependencies
package lppu_pkg;

    // default sizes, handed to the top level parameters
    localparam int SPRITE_RAM_BYTES_DEF = 160;
    localparam int VIDEO_RAM_BYTES_DEF  = 8192;
    localparam int LINES_PER_FRAME_DEF  = 154;

    // item operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // register map
    localparam logic [15:0] ADDR_LCDC = 16'hFF40;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_SCY  = 16'hFF42;
    localparam logic [15:0] ADDR_SCX  = 16'hFF43;
    localparam logic [15:0] ADDR_LY   = 16'hFF44;
    localparam logic [15:0] ADDR_LYC  = 16'hFF45;
    localparam logic [15:0] ADDR_BGP  = 16'hFF47;
    localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
    localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
    localparam logic [15:0] ADDR_WY   = 16'hFF4A;
    localparam logic [15:0] ADDR_WX   = 16'hFF4B;

    localparam logic [15:0] VRAM_BASE = 16'h8000;
    localparam logic [15:0] VRAM_TOP  = 16'h9FFF;
    localparam logic [15:0] OAM_BASE  = 16'hFE00;

    localparam logic [7:0] BYTE_BLOCKED = 8'hFF;
    localparam logic [7:0] VBLANK_LINE  = 8'd144;

    // dot counts per mode, loaded as count minus one
    localparam logic [6:0] DOTS_OAM    = 7'd19;
    localparam logic [6:0] DOTS_DRAW   = 7'd71;
    localparam logic [6:0] DOTS_HBLANK = 7'd21;
    localparam logic [6:0] DOTS_VBLANK = 7'd113;

    // lcd control bit that runs the mode timer
    localparam int LCDC_ENABLE_BIT = 7;

    typedef enum logic [1:0] {
        PH_HBLANK = 2'd0,
        PH_VBLANK = 2'd1,
        PH_OAM    = 2'd2,
        PH_DRAW   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] lcd_mode;
        logic [7:0] line;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

endpackage

@@ design/lcd_ppu_registers_and_mode_timer.sv @@
// lcd_ppu_registers_and_mode_timer: top level of the lcd picture unit bus view
// depends on lppu_pkg, lppu_ctrl, lppu_dp (which holds the lppu_ram instances)
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-------------------------------
//  item    | in        | i_valid / o_ready      | i_data  (mode, address, data)
//  result  | out       | o_valid / i_ready      | o_data  (read_data, mode, line)
//
//  every word goes through accept, execute,
//  ram read return, result offered; the registered read port of the rams sets
//  the middle step and the sequencer holds one word at a time
//  a stalled result holds o_valid and o_data until i_ready, and no new word is
//  accepted meanwhile
//  reset (i_rst_n low, synchronous) clears state, lcd registers, line 0, oam scan
//  mode; item, result and ram contents are left, ram reads garbage until written
module lcd_ppu_registers_and_mode_timer
    import lppu_pkg::*;
#(
    parameter int SPRITE_RAM_BYTES = SPRITE_RAM_BYTES_DEF,
    parameter int VIDEO_RAM_BYTES  = VIDEO_RAM_BYTES_DEF,
    parameter int LINES_PER_FRAME  = LINES_PER_FRAME_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    // command bundle from the sequencer to the datapath
    t_cmd cmd;

    lppu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_out_ready(i_ready),
        .o_in_ready (o_ready),
        .o_out_valid(o_valid),
        .o_cmd      (cmd)
    );

    // registers, mode timer and both rams
    lppu_dp #(
        .SPRITE_RAM_BYTES(SPRITE_RAM_BYTES),
        .VIDEO_RAM_BYTES (VIDEO_RAM_BYTES),
        .LINES_PER_FRAME (LINES_PER_FRAME)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_data),
        .o_result(o_data)
    );

endmodule

@@ design/lppu_ram.sv @@
// lppu_ram: generic single port ram with registered read
// no dependencies
module lppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/lppu_ctrl.sv @@
// lppu_ctrl: sequencer taking one word at a time through execute, load, respond
// depends on lppu_pkg
module lppu_ctrl
    import lppu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LOAD = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_LOAD;
            S_LOAD: n_state = S_RESP;
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_RESP);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load    = (r_state == S_LOAD);

endmodule

@@ design/lppu_dp.sv @@
// lppu_dp: register file, mode timer, video and sprite rams, result register
// depends on lppu_pkg and lppu_ram
module lppu_dp
    import lppu_pkg::*;
#(
    parameter int SPRITE_RAM_BYTES = SPRITE_RAM_BYTES_DEF,
    parameter int VIDEO_RAM_BYTES  = VIDEO_RAM_BYTES_DEF,
    parameter int LINES_PER_FRAME  = LINES_PER_FRAME_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_item,
    output t_out o_result
);

    localparam int SAW = $clog2(SPRITE_RAM_BYTES);
    localparam int VAW = $clog2(VIDEO_RAM_BYTES);

    t_in        r_item;
    t_out       r_out;
    logic [7:0] r_lcdc, r_scy, r_scx, r_ly, r_lyc, r_wy, r_wx;
    logic [7:0] r_pal [3];
    logic [4:0] r_stat_en;
    t_phase     r_phase;
    logic [6:0] r_dots;

    logic [15:0] oam_off, vram_off;
    logic        oam_hit, vram_hit, oam_open, vram_open;
    logic        is_write, oam_we, vram_we, tick_en;
    logic [7:0]  oam_rdata, vram_rdata, rd_byte;
    logic [8:0]  ly_inc;
    logic [7:0]  ly_next;

    assign oam_off  = r_item.address - OAM_BASE;
    assign vram_off = r_item.address - VRAM_BASE;
    assign oam_hit  = (r_item.address >= OAM_BASE) && (oam_off < 16'(SPRITE_RAM_BYTES));
    assign vram_hit = (r_item.address >= VRAM_BASE) && (r_item.address <= VRAM_TOP)
                      && (vram_off < 16'(VIDEO_RAM_BYTES));
    assign oam_open  = (r_phase == PH_HBLANK) || (r_phase == PH_VBLANK);
    assign vram_open = (r_phase != PH_DRAW);

    assign is_write = i_cmd.exec && (r_item.mode == OP_WRITE);
    assign oam_we   = is_write && oam_hit && oam_open;
    assign vram_we  = is_write && vram_hit && vram_open;
    assign tick_en  = i_cmd.exec && (r_item.mode == OP_TICK) && r_lcdc[LCDC_ENABLE_BIT];

    assign ly_inc  = {1'b0, r_ly} + 9'd1;
    assign ly_next = (ly_inc == 9'(LINES_PER_FRAME)) ? 8'd0 : ly_inc[7:0];

    lppu_ram #(.WIDTH(8), .DEPTH(SPRITE_RAM_BYTES)) u_oam (
        .i_clk  (i_clk),
        .i_we   (oam_we),
        .i_addr (oam_off[SAW-1:0]),
        .i_wdata(r_item.write_data),
        .o_rdata(oam_rdata)
    );

    lppu_ram #(.WIDTH(8), .DEPTH(VIDEO_RAM_BYTES)) u_vram (
        .i_clk  (i_clk),
        .i_we   (vram_we),
        .i_addr (vram_off[VAW-1:0]),
        .i_wdata(r_item.write_data),
        .o_rdata(vram_rdata)
    );

    // item and result hold payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.load) begin
            r_out.read_data <= (r_item.mode == OP_READ) ? rd_byte : 8'd0;
            r_out.lcd_mode  <= 2'(r_phase);
            r_out.line      <= r_ly;
        end
    end

    // register reads, then the rams, blocked by phase
    always_comb begin
        unique case (r_item.address)
            ADDR_LCDC: rd_byte = r_lcdc;
            ADDR_STAT: rd_byte = {r_stat_en, (r_ly == r_lyc), 2'(r_phase)};
            ADDR_SCY:  rd_byte = r_scy;
            ADDR_SCX:  rd_byte = r_scx;
            ADDR_LY:   rd_byte = r_ly;
            ADDR_LYC:  rd_byte = r_lyc;
            ADDR_BGP:  rd_byte = r_pal[0];
            ADDR_OBP0: rd_byte = r_pal[1];
            ADDR_OBP1: rd_byte = r_pal[2];
            ADDR_WY:   rd_byte = r_wy;
            ADDR_WX:   rd_byte = r_wx;
            default: begin
                if (oam_hit) begin
                    rd_byte = oam_open ? oam_rdata : BYTE_BLOCKED;
                end else if (vram_hit) begin
                    rd_byte = vram_open ? vram_rdata : BYTE_BLOCKED;
                end else begin
                    rd_byte = BYTE_BLOCKED;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc    <= '0;
            r_stat_en <= '0;
            r_scy     <= '0;
            r_scx     <= '0;
            r_ly      <= '0;
            r_lyc     <= '0;
            r_pal[0]  <= '0;
            r_pal[1]  <= '0;
            r_pal[2]  <= '0;
            r_wy      <= '0;
            r_wx      <= '0;
            r_phase   <= PH_OAM;
            r_dots    <= '0;
        end else begin
            if (is_write) begin
                unique case (r_item.address)
                    ADDR_LCDC: r_lcdc    <= r_item.write_data;
                    ADDR_STAT: r_stat_en <= r_item.write_data[7:3];
                    ADDR_SCY:  r_scy     <= r_item.write_data;
                    ADDR_SCX:  r_scx     <= r_item.write_data;
                    ADDR_LYC:  r_lyc     <= r_item.write_data;
                    ADDR_BGP:  r_pal[0]  <= r_item.write_data;
                    ADDR_OBP0: r_pal[1]  <= r_item.write_data;
                    ADDR_OBP1: r_pal[2]  <= r_item.write_data;
                    ADDR_WY:   r_wy      <= r_item.write_data;
                    ADDR_WX:   r_wx      <= r_item.write_data;
                    default: ;
                endcase
            end
            if (tick_en) begin
                if (r_dots != 7'd0) begin
                    r_dots <= r_dots - 7'd1;
                end else begin
                    case (r_phase)
                        PH_OAM: begin
                            r_phase <= PH_DRAW;
                            r_dots  <= DOTS_DRAW;
                        end
                        PH_DRAW: begin
                            r_phase <= PH_HBLANK;
                            r_dots  <= DOTS_HBLANK;
                        end
                        PH_HBLANK: begin
                            r_ly <= ly_next;
                            if (ly_next == VBLANK_LINE) begin
                                r_phase <= PH_VBLANK;
                                r_dots  <= DOTS_VBLANK;
                            end else begin
                                r_phase <= PH_OAM;
                                r_dots  <= DOTS_OAM;
                            end
                        end
                        default: begin
                            r_ly <= ly_next;
                            if (ly_next == 8'd0) begin
                                r_phase <= PH_OAM;
                                r_dots  <= DOTS_OAM;
                            end else begin
                                r_dots  <= DOTS_VBLANK;
                            end
                        end
                    endcase
                end
            end
        end
    end

    assign o_result = r_out;

endmodule

@@ design/lppu_checker.sv @@
// lppu_checker: port level assertions for the lcd picture unit top level
// depends on lppu_pkg; bound to lcd_ppu_registers_and_mode_timer below
module lppu_checker
    import lppu_pkg::*;
#(
    parameter int LINES_PER_FRAME = LINES_PER_FRAME_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input t_in  i_data,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    // waiting item word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data))
        else $error("item word changed while waiting");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // one word at a time
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready && !o_valid)
        else $error("second word taken while busy");

    // result offered once the execute and load states that follow acceptance have passed
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |-> ##3 o_valid)
        else $error("result not offered in time");

    // line stays inside the frame
    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.line < 8'(LINES_PER_FRAME))
        else $error("line beyond frame");

endmodule

bind lcd_ppu_registers_and_mode_timer lppu_checker #(
    .LINES_PER_FRAME(LINES_PER_FRAME)
) u_lppu_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .i_data (i_data),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);

@@ dv/lppu_bus_checker.sv @@
`timescale 1ns / 100ps
// lppu_bus_checker: watches the item and result channels of the lcd picture unit,
// predicts every result word from its own copy of the registers and rams
// depends on lppu_pkg for the word types, bus map and dot counts
module lppu_bus_checker
    import lppu_pkg::*;
#(
    parameter int SPRITE_RAM_BYTES = SPRITE_RAM_BYTES_DEF,
    parameter int VIDEO_RAM_BYTES  = VIDEO_RAM_BYTES_DEF,
    parameter int LINES_PER_FRAME  = LINES_PER_FRAME_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_item_valid,
    input  logic i_item_ready,
    input  t_in  i_item,
    input  logic i_result_valid,
    input  logic i_result_ready,
    input  t_out i_result,
    output int   o_fail_count,
    output int   o_pending
);

    // predicted register file and timer
    logic [7:0] lcdc;
    logic [4:0] stat_en;
    logic [7:0] scy;
    logic [7:0] scx;
    logic [7:0] ly;
    logic [7:0] lyc;
    logic [7:0] pal [3];
    logic [7:0] win [2];
    t_phase     ph;
    logic [6:0] dots;
    logic [7:0] vram [VIDEO_RAM_BYTES];
    logic [7:0] oam  [SPRITE_RAM_BYTES];

    t_out results_due [$];
    int   fails = 0;

    assign o_fail_count = fails;

    function automatic bit is_vram(input logic [15:0] a);
        return a >= VRAM_BASE && a <= VRAM_TOP
            && (int'(a) - int'(VRAM_BASE)) < VIDEO_RAM_BYTES;
    endfunction

    function automatic bit is_oam(input logic [15:0] a);
        return a >= OAM_BASE && (int'(a) - int'(OAM_BASE)) < SPRITE_RAM_BYTES;
    endfunction

    function automatic bit oam_open();
        return ph == PH_HBLANK || ph == PH_VBLANK;
    endfunction

    function automatic logic [7:0] bus_read_byte(input logic [15:0] a);
        case (a)
            ADDR_LCDC: return lcdc;
            ADDR_STAT: return {stat_en, ly == lyc, ph};
            ADDR_SCY:  return scy;
            ADDR_SCX:  return scx;
            ADDR_LY:   return ly;
            ADDR_LYC:  return lyc;
            ADDR_BGP:  return pal[0];
            ADDR_OBP0: return pal[1];
            ADDR_OBP1: return pal[2];
            ADDR_WY:   return win[0];
            ADDR_WX:   return win[1];
            default: ;
        endcase
        if (is_oam(a))
            return oam_open() ? oam[a - OAM_BASE] : BYTE_BLOCKED;
        if (is_vram(a))
            return (ph != PH_DRAW) ? vram[a - VRAM_BASE] : BYTE_BLOCKED;
        return BYTE_BLOCKED;
    endfunction

    function automatic void bus_write_byte(input logic [15:0] a, input logic [7:0] v);
        case (a)
            ADDR_LCDC: lcdc = v;
            ADDR_STAT: stat_en = v[7:3];
            ADDR_SCY:  scy = v;
            ADDR_SCX:  scx = v;
            ADDR_LY:   ;
            ADDR_LYC:  lyc = v;
            ADDR_BGP:  pal[0] = v;
            ADDR_OBP0: pal[1] = v;
            ADDR_OBP1: pal[2] = v;
            ADDR_WY:   win[0] = v;
            ADDR_WX:   win[1] = v;
            default: begin
                if (is_oam(a)) begin
                    if (oam_open())
                        oam[a - OAM_BASE] = v;
                end else if (is_vram(a) && ph != PH_DRAW) begin
                    vram[a - VRAM_BASE] = v;
                end
            end
        endcase
    endfunction

    function automatic void step_dot_timer();
        if (!lcdc[LCDC_ENABLE_BIT])
            return;
        if (dots != 7'd0) begin
            dots = dots - 7'd1;
            return;
        end
        case (ph)
            PH_OAM:  ph = PH_DRAW;
            PH_DRAW: ph = PH_HBLANK;
            PH_HBLANK: begin
                ly = (ly == 8'(LINES_PER_FRAME - 1)) ? 8'd0 : ly + 8'd1;
                ph = (ly == VBLANK_LINE) ? PH_VBLANK : PH_OAM;
            end
            default: begin
                ly = (ly == 8'(LINES_PER_FRAME - 1)) ? 8'd0 : ly + 8'd1;
                if (ly == 8'd0)
                    ph = PH_OAM;
            end
        endcase
        case (ph)
            PH_OAM:    dots = DOTS_OAM;
            PH_DRAW:   dots = DOTS_DRAW;
            PH_HBLANK: dots = DOTS_HBLANK;
            default:   dots = DOTS_VBLANK;
        endcase
    endfunction

    function automatic t_out predict_bus_result(input t_in w);
        t_out r;
        r = '0;
        case (w.mode)
            OP_READ:  r.read_data = bus_read_byte(w.address);
            OP_WRITE: bus_write_byte(w.address, w.write_data);
            OP_TICK:  step_dot_timer();
            default: ;
        endcase
        r.lcd_mode = ph;
        r.line     = ly;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out due;
        if (!i_rst_n) begin
            lcdc    = '0;
            stat_en = '0;
            scy     = '0;
            scx     = '0;
            ly      = '0;
            lyc     = '0;
            pal     = '{default: '0};
            win     = '{default: '0};
            ph      = PH_OAM;
            dots    = '0;
            results_due.delete();
        end else begin
            // retire first, a word accepted now cannot have its result yet
            if (i_result_valid && i_result_ready) begin
                if (results_due.size() == 0) begin
                    $error("result word with no prediction waiting");
                    fails++;
                end else begin
                    due = results_due.pop_front();
                    check_field("read_data", due.read_data, i_result.read_data);
                    check_field("lcd_mode", 8'(due.lcd_mode), 8'(i_result.lcd_mode));
                    check_field("line", due.line, i_result.line);
                end
            end
            if (i_item_valid && i_item_ready)
                results_due.push_back(predict_bus_result(i_item));
        end
        o_pending <= results_due.size();
    end

endmodule

@@ dv/tb_lcd_ppu_registers_and_mode_timer.sv @@
`timescale 1ns / 100ps
// tb_lcd_ppu_registers_and_mode_timer: stimulus and verdict for the lcd picture unit
// depends on lppu_pkg, the block under test and lppu_bus_checker
module tb_lcd_ppu_registers_and_mode_timer;
    import lppu_pkg::*;

    // the package names only three operations, the fourth code is a no-op
    localparam logic [1:0] OP_IGNORED = 2'd3;

    // memory bytes that get written before any read may touch them
    localparam logic [7:0][15:0] VRAM_POOL = {
        16'h8000, 16'h9FFF, 16'h8001, 16'h9800,
        16'h8AAA, 16'h9555, 16'h8FFF, 16'h9000
    };
    localparam logic [7:0][15:0] OAM_POOL = {
        16'hFE00, 16'hFE9F, 16'hFE01, 16'hFE50,
        16'hFE2A, 16'hFE75, 16'hFE80, 16'hFE9E
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data  = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    int fail_count;
    int words_pending;
    bit idle_on    = 1'b0;
    int stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lcd_ppu_registers_and_mode_timer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // prediction and comparison live beside the block, not in the stimulus
    lppu_bus_checker u_bus_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (i_valid),
        .i_item_ready   (o_ready),
        .i_item         (i_data),
        .i_result_valid (o_valid),
        .i_result_ready (i_ready),
        .i_result       (o_data),
        .o_fail_count   (fail_count),
        .o_pending      (words_pending)
    );

    // result side back-pressure: random bursts with i_ready low while idling is on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // offers one word and returns at the edge that takes it; an optional
    // gap with i_valid low goes in front when idling is on
    task automatic send_bus_word(input logic [1:0] mode, input logic [15:0] addr,
                                 input logic [7:0] data);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= {mode, addr, data};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // extremes turn up often
    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // read addresses never land on a ram byte that has not been written:
    // only the pools, the registers and unmapped space are read
    function automatic logic [15:0] safe_read_address();
        logic [15:0] a;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: a = ADDR_LCDC + 16'($urandom_range(0, 11));
            4:          a = VRAM_POOL[$urandom_range(0, 7)];
            5:          a = OAM_POOL[$urandom_range(0, 7)];
            6:          a = {8'hFE, 8'($urandom_range(8'hA0, 8'hFF))};
            7:          a = {8'hFF, 8'($urandom_range(0, 255))};
            default: begin
                a = 16'($urandom);
                while ((a >= VRAM_BASE && a <= VRAM_TOP)
                       || (a >= OAM_BASE && a < OAM_BASE + 16'(SPRITE_RAM_BYTES_DEF)))
                    a = 16'($urandom);
            end
        endcase
        return a;
    endfunction

    // writes may go anywhere, including ram bytes that are never read back
    function automatic logic [15:0] any_write_address();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return ADDR_LCDC + 16'($urandom_range(0, 11));
            4:          return {3'b100, 13'($urandom)};
            5:          return OAM_BASE + 16'($urandom_range(0, SPRITE_RAM_BYTES_DEF - 1));
            6:          return VRAM_POOL[$urandom_range(0, 7)];
            7:          return OAM_POOL[$urandom_range(0, 7)];
            default:    return 16'($urandom);
        endcase
    endfunction

    // one random word of the general mix; control writes mostly keep the
    // lcd running so that the timer gets somewhere
    task automatic random_bus_word();
        logic [15:0] a;
        logic [7:0]  d;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6:
                send_bus_word(OP_READ, safe_read_address(), random_byte());
            7, 8, 9, 10, 11, 12: begin
                a = any_write_address();
                d = random_byte();
                if (a == ADDR_LCDC)
                    d[LCDC_ENABLE_BIT] = ($urandom_range(0, 3) != 0);
                send_bus_word(OP_WRITE, a, d);
            end
            13:
                send_bus_word(OP_IGNORED, 16'($urandom), random_byte());
            default:
                send_bus_word(OP_TICK, 16'($urandom), random_byte());
        endcase
    endtask

    initial begin
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;

        // registers straight after reset, plus unmapped and out-of-size space
        for (int i = 0; i < 12; i++)
            send_bus_word(OP_READ, ADDR_LCDC + 16'(i), 8'h00);
        send_bus_word(OP_READ, 16'h0000, 8'hFF);
        send_bus_word(OP_READ, 16'hFFFF, 8'h00);
        send_bus_word(OP_READ, 16'hFEA0, 8'h00);

        // video ram is open in oam scan, so its pool can be filled now
        for (int i = 0; i < 8; i++)
            send_bus_word(OP_WRITE, VRAM_POOL[i], random_byte());

        // all ones into every register but control, the line register and
        // the unmapped hole at ff46 must ignore it
        for (int i = 1; i < 12; i++)
            send_bus_word(OP_WRITE, ADDR_LCDC + 16'(i), 8'hFF);
        for (int i = 1; i < 12; i++)
            send_bus_word(OP_READ, ADDR_LCDC + 16'(i), 8'h00);
        send_bus_word(OP_IGNORED, 16'hFFFF, 8'hFF);
        send_bus_word(OP_WRITE, 16'hFEA0, 8'h5A);
        send_bus_word(OP_READ, VRAM_POOL[0], 8'h00);

        // run the timer from oam scan through draw into hblank: one tick to
        // leave oam scan, 71 to drain draw, one more to enter hblank
        send_bus_word(OP_WRITE, ADDR_LYC, 8'h00);
        send_bus_word(OP_WRITE, ADDR_LCDC, 8'h80);
        for (int k = 0; k < 73; k++) begin
            send_bus_word(OP_TICK, 16'h0000, 8'h00);
            if (k == 0) begin
                // draw: video ram is closed both ways, sprite ram writes dropped
                send_bus_word(OP_READ, VRAM_POOL[0], 8'h00);
                send_bus_word(OP_WRITE, VRAM_POOL[0], 8'hAA);
                send_bus_word(OP_WRITE, OAM_POOL[0], 8'h55);
                send_bus_word(OP_READ, ADDR_STAT, 8'h00);
            end
        end
        send_bus_word(OP_READ, ADDR_STAT, 8'h00);

        // freeze in hblank with the lcd off, then fill and read back sprite ram
        send_bus_word(OP_WRITE, ADDR_LCDC, 8'h00);
        for (int i = 0; i < 8; i++)
            send_bus_word(OP_WRITE, OAM_POOL[i], random_byte());
        for (int i = 0; i < 8; i++)
            send_bus_word(OP_READ, OAM_POOL[i], 8'h00);
        send_bus_word(OP_TICK, 16'hFFFF, 8'hFF);
        send_bus_word(OP_READ, ADDR_STAT, 8'h00);

        // general random mix, idling switched on and off in stretches
        for (n = 0; n < 400; n++) begin
            if (n % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            random_bus_word();
        end

        // tick run with the lcd on, mostly ticks with accesses in between,
        // so the timer crosses mode and line boundaries under traffic
        send_bus_word(OP_WRITE, ADDR_LCDC, 8'h91);
        for (n = 0; n < 150; n++) begin
            if (n % 50 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 15) != 0) begin
                send_bus_word(OP_TICK, 16'($urandom), random_byte());
            end else begin
                case ($urandom_range(0, 4))
                    0: send_bus_word(OP_READ, safe_read_address(), 8'h00);
                    1: send_bus_word(OP_READ, ADDR_STAT, 8'h00);
                    2: send_bus_word(OP_WRITE, ADDR_LYC, 8'($urandom_range(0, 153)));
                    3: send_bus_word(OP_WRITE, VRAM_POOL[$urandom_range(0, 7)],
                                     random_byte());
                    default: send_bus_word(OP_WRITE, OAM_POOL[$urandom_range(0, 7)],
                                           random_byte());
                endcase
            end
        end

        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        for (n = 0; n < 50; n++)
            random_bus_word();
        i_valid <= 1'b0;

        // drain the outstanding predictions, then keep the clock running for
        // any stray result word
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // hang guard, well beyond the slowest correct run
    initial begin
        #15_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
design/lppu_pkg.sv
design/lppu_ram.sv
design/lppu_ctrl.sv
design/lppu_dp.sv
design/lcd_ppu_registers_and_mode_timer.sv
design/lppu_checker.sv
dv/lppu_bus_checker.sv
dv/tb_lcd_ppu_registers_and_mode_timer.sv
